// ===== rtl/skyline_atlas_allocator_core_macros.svh =====
// assertion macros for the skyline atlas allocator
`ifndef SKYLINE_ATLAS_ALLOCATOR_CORE_MACROS_SVH
`define SKYLINE_ATLAS_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define SAL_ASSERT_SAME(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("sal assertion failed");

// next-cycle implication, disabled during reset
`define SAL_ASSERT_NEXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("sal assertion failed");

`endif

// ===== rtl/sal_pkg.sv =====
// shared types and codes for the skyline atlas allocator
`timescale 1ns / 1ps
package sal_pkg;

   typedef enum logic [2:0] {
      CELL_HOLD  = 3'd0,
      CELL_LOAD  = 3'd1,
      CELL_LOADZ = 3'd2,
      CELL_WIN   = 3'd3,
      CELL_SCAN  = 3'd4,
      CELL_RAISE = 3'd5,
      CELL_FILL  = 3'd6,
      CELL_CLEAR = 3'd7
   } cell_op_type;

   typedef enum logic [1:0] {
      SCAN_HOLD = 2'd0,
      SCAN_INIT = 2'd1,
      SCAN_STEP = 2'd2
   } scan_op_type;

   localparam logic       ACT_RESTART    = 1'b1;

   localparam logic [2:0] STAT_PLACED    = 3'd0;
   localparam logic [2:0] STAT_NEW_PAGE  = 3'd1;
   localparam logic [2:0] STAT_TOO_LARGE = 3'd2;
   localparam logic [2:0] STAT_EXHAUSTED = 3'd3;
   localparam logic [2:0] STAT_RESTART   = 3'd4;

endpackage

// ===== rtl/sal_cell.sv =====
// one skyline column cell: height, sliding window shift and running maximum
`timescale 1ns / 1ps
module sal_cell
   import sal_pkg::*;
#(
   parameter int HEIGHT_W = 8,
   parameter int COL_W    = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  cell_op_type         op,
   input  logic [COL_W-1:0]    col,
   input  logic [COL_W-1:0]    bx,
   input  logic [COL_W-1:0]    xend,
   input  logic [HEIGHT_W-1:0] new_h,
   input  logic [HEIGHT_W-1:0] s_nxt,
   input  logic [HEIGHT_W-1:0] m_nxt,
   output logic [HEIGHT_W-1:0] s,
   output logic [HEIGHT_W-1:0] m
);

   logic [HEIGHT_W-1:0] h_ff, h_in;
   logic [HEIGHT_W-1:0] s_ff, s_in;
   logic [HEIGHT_W-1:0] m_ff, m_in;
   logic                in_rng;

   assign in_rng = (col >= bx) && (col < xend);

   always_comb begin
      h_in = h_ff;
      s_in = s_ff;
      m_in = m_ff;
      case (op)
         CELL_LOAD: begin
            s_in = h_ff;
            m_in = h_ff;
         end
         CELL_LOADZ: begin
            // zero width window has maximum zero
            s_in = h_ff;
            m_in = '0;
         end
         CELL_WIN: begin
            s_in = s_nxt;
            if (s_nxt > m_ff) begin
               m_in = s_nxt;
            end
         end
         CELL_SCAN: begin
            m_in = m_nxt;
         end
         CELL_RAISE: begin
            if (in_rng) begin
               h_in = new_h;
            end
         end
         CELL_FILL: begin
            // fresh page with the rectangle placed at the left edge
            h_in = in_rng ? new_h : '0;
         end
         CELL_CLEAR: begin
            h_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff <= '0;
      end else begin
         h_ff <= h_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff <= s_in;
      m_ff <= m_in;
   end

   assign s = s_ff;
   assign m = m_ff;

endmodule

// ===== rtl/sal_scan.sv =====
// leftmost-minimum tracker fed by the window maxima leaving the head cell
`timescale 1ns / 1ps
module sal_scan
   import sal_pkg::*;
#(
   parameter int HEIGHT_W     = 8,
   parameter int COL_W        = 8,
   parameter int ATLAS_HEIGHT = 128
) (
   input  logic                clock,
   input  logic                reset,
   input  scan_op_type         op,
   input  logic [HEIGHT_W-1:0] m_head,
   input  logic [COL_W-1:0]    idx,
   output logic [HEIGHT_W-1:0] best,
   output logic [COL_W-1:0]    bx,
   output logic                found
);

   logic [HEIGHT_W-1:0] best_ff, best_in;
   logic [COL_W-1:0]    bx_ff, bx_in;
   logic                found_ff, found_in;

   always_comb begin
      best_in  = best_ff;
      bx_in    = bx_ff;
      found_in = found_ff;
      case (op)
         SCAN_INIT: begin
            best_in  = HEIGHT_W'(ATLAS_HEIGHT);
            bx_in    = '0;
            found_in = 1'b0;
         end
         SCAN_STEP: begin
            // strict compare keeps the leftmost of equal minima
            if (m_head < best_ff) begin
               best_in  = m_head;
               bx_in    = idx;
               found_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
      bx_ff   <= bx_in;
   end

   assign best  = best_ff;
   assign bx    = bx_ff;
   assign found = found_ff;

endmodule

// ===== rtl/skyline_atlas_allocator_core.sv =====
// top level of the skyline atlas allocator: sequencer, page state and cell row
`timescale 1ns / 1ps
`include "skyline_atlas_allocator_core_macros.svh"

// Packs rectangles into atlas pages with a per-column skyline held in a row
// of ATLAS_WIDTH cells. A request is taken when start is high and busy is
// low; exactly one response follows as a one-cycle rsp_valid strobe that
// cannot be held off, and busy drops in the same cycle. A restart or a
// request while halted is answered from the dispatch state. An allocation
// of width w runs through a dispatch state, a window build that forms the
// window maxima in the cells, a scan that shifts them out of the head cell
// past the minimum tracker, a decision state and the response; a fail
// state is added when a new page has to be opened, and a zero width needs
// no build step. Widths of ATLAS_WIDTH or more skip the scan and go
// straight to the fail state, which answers too large or exhausted.
module skyline_atlas_allocator_core
   import sal_pkg::*;
#(
   parameter int ATLAS_WIDTH  = 128,
   parameter int ATLAS_HEIGHT = 128,
   parameter int PAGE_COUNT   = 128
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_action,
   input  logic [7:0] req_rect_width,
   input  logic [7:0] req_rect_height,
   output logic       rsp_valid,
   output logic [6:0] rsp_pos_x,
   output logic [6:0] rsp_pos_y,
   output logic [7:0] rsp_page,
   output logic [2:0] rsp_status
);

   localparam int CW = $clog2(ATLAS_WIDTH + 1);
   localparam int HW = $clog2(ATLAS_HEIGHT + 1);
   localparam int PW = $clog2(PAGE_COUNT + 1);
   localparam int XW = (CW > 8) ? CW : 8;
   localparam int FW = HW + 9;

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_DISPATCH = 6'b000010,
      ST_WIN      = 6'b000100,
      ST_SCAN     = 6'b001000,
      ST_DECIDE   = 6'b010000,
      ST_FAIL     = 6'b100000
   } state_type;

   state_type      state_ff, state_in;
   logic           act_ff;
   logic [7:0]     w_ff;
   logic [7:0]     h_ff;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [PW-1:0]  page_ff, page_in, page_next;
   logic           halted_ff, halted_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [6:0]     rsp_x_ff, rsp_x_in;
   logic [6:0]     rsp_y_ff, rsp_y_in;
   logic [7:0]     rsp_page_ff, rsp_page_in;
   logic [2:0]     rsp_status_ff, rsp_status_in;

   cell_op_type    cell_op;
   scan_op_type    scan_op;
   logic [CW-1:0]  bx_sel, xend;
   logic [HW-1:0]  new_h;
   logic [HW-1:0]  scan_best;
   logic [CW-1:0]  scan_bx;
   logic           scan_found;
   logic [HW-1:0]  s_arr [ATLAS_WIDTH];
   logic [HW-1:0]  m_arr [ATLAS_WIDTH];

   logic [XW-1:0]  w_x;
   logic [XW-1:0]  scan_last;
   logic           wide;
   logic [FW-1:0]  fit_sum;
   logic           fits;
   logic           retry_fits;
   logic           accept;

   assign accept     = start && !busy;
   assign busy       = (state_ff != ST_IDLE);
   assign w_x        = XW'(w_ff);
   assign wide       = (w_x >= XW'(ATLAS_WIDTH));
   assign scan_last  = XW'(ATLAS_WIDTH) - w_x - XW'(1);
   assign fit_sum    = FW'(scan_best) + FW'(h_ff);
   assign fits       = scan_found && (fit_sum <= FW'(ATLAS_HEIGHT));
   assign retry_fits = !wide && (FW'(h_ff) <= FW'(ATLAS_HEIGHT));
   assign page_next  = page_ff + PW'(1);
   assign xend       = bx_sel + CW'(w_ff);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      page_in       = page_ff;
      halted_in     = halted_ff;
      cell_op       = CELL_HOLD;
      scan_op       = SCAN_HOLD;
      bx_sel        = scan_bx;
      new_h         = HW'(fit_sum);
      rsp_valid_in  = 1'b0;
      rsp_x_in      = '0;
      rsp_y_in      = '0;
      rsp_status_in = STAT_PLACED;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            scan_op = SCAN_INIT;
            if (act_ff == ACT_RESTART) begin
               cell_op       = CELL_CLEAR;
               page_in       = PW'(1);
               halted_in     = 1'b0;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_RESTART;
               state_in      = ST_IDLE;
            end else if (halted_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_EXHAUSTED;
               state_in      = ST_IDLE;
            end else if (wide) begin
               state_in = ST_FAIL;
            end else begin
               cell_op = (w_ff == 8'd0) ? CELL_LOADZ : CELL_LOAD;
               if (w_ff <= 8'd1) begin
                  cnt_in   = '0;
                  state_in = ST_SCAN;
               end else begin
                  cnt_in   = CW'(1);
                  state_in = ST_WIN;
               end
            end
         end
         ST_WIN: begin
            cell_op = CELL_WIN;
            if (XW'(cnt_ff) == w_x - XW'(1)) begin
               cnt_in   = '0;
               state_in = ST_SCAN;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         ST_SCAN: begin
            cell_op = CELL_SCAN;
            scan_op = SCAN_STEP;
            if (XW'(cnt_ff) == scan_last) begin
               state_in = ST_DECIDE;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         ST_DECIDE: begin
            if (fits) begin
               cell_op       = CELL_RAISE;
               rsp_valid_in  = 1'b1;
               rsp_x_in      = 7'(scan_bx);
               rsp_y_in      = 7'(scan_best);
               rsp_status_in = STAT_PLACED;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_FAIL;
            end
         end
         ST_FAIL: begin
            page_in      = page_next;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            bx_sel       = '0;
            new_h        = HW'(h_ff);
            if (page_next == PW'(PAGE_COUNT)) begin
               halted_in     = 1'b1;
               rsp_status_in = STAT_EXHAUSTED;
            end else if (retry_fits) begin
               // on an empty page the leftmost spot at row zero always wins
               cell_op       = CELL_FILL;
               rsp_status_in = STAT_NEW_PAGE;
            end else begin
               cell_op       = CELL_CLEAR;
               halted_in     = 1'b1;
               rsp_status_in = STAT_TOO_LARGE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_page_in = 8'(page_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         page_ff      <= PW'(1);
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         page_ff      <= page_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff <= req_action;
         w_ff   <= req_rect_width;
         h_ff   <= req_rect_height;
      end
      if (rsp_valid_in) begin
         rsp_x_ff      <= rsp_x_in;
         rsp_y_ff      <= rsp_y_in;
         rsp_page_ff   <= rsp_page_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_pos_x  = rsp_x_ff;
   assign rsp_pos_y  = rsp_y_ff;
   assign rsp_page   = rsp_page_ff;
   assign rsp_status = rsp_status_ff;

   // column row: window data moves one cell toward column zero per cycle in the window and scan states
   for (genvar k = 0; k < ATLAS_WIDTH; k++) begin : g_col
      logic [HW-1:0] s_nxt;
      logic [HW-1:0] m_nxt;
      if (k == ATLAS_WIDTH - 1) begin : g_last
         assign s_nxt = '0;
         assign m_nxt = '0;
      end else begin : g_mid
         assign s_nxt = s_arr[k+1];
         assign m_nxt = m_arr[k+1];
      end
      sal_cell #(
         .HEIGHT_W (HW),
         .COL_W    (CW)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .op    (cell_op),
         .col   (CW'(k)),
         .bx    (bx_sel),
         .xend  (xend),
         .new_h (new_h),
         .s_nxt (s_nxt),
         .m_nxt (m_nxt),
         .s     (s_arr[k]),
         .m     (m_arr[k])
      );
   end

   sal_scan #(
      .HEIGHT_W     (HW),
      .COL_W        (CW),
      .ATLAS_HEIGHT (ATLAS_HEIGHT)
   ) u_scan (
      .clock  (clock),
      .reset  (reset),
      .op     (scan_op),
      .m_head (m_arr[0]),
      .idx    (cnt_ff),
      .best   (scan_best),
      .bx     (scan_bx),
      .found  (scan_found)
   );

   `SAL_ASSERT_SAME(a_rsp_when_idle, clock, reset, rsp_valid, !busy)
   `SAL_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy && !rsp_valid)
   `SAL_ASSERT_SAME(a_found_in_range, clock, reset, scan_found, scan_best < HW'(ATLAS_HEIGHT))

endmodule
